[rtl/cau_pkg.sv]
// Shared types, constants and the arctangent table of the complex arithmetic unit.
// Used by cau_iter_stage and complex_arithmetic_unit; depends on nothing.
package cau_pkg;

    localparam int ANG_W        = 34;
    localparam int CX_W         = 36;
    localparam int ANG_BITS     = 30;
    localparam int CORDIC_STEPS = 30;
    localparam int ITER_STAGES  = 32;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

    localparam logic [2:0] FN_ADD = 3'd0;
    localparam logic [2:0] FN_SUB = 3'd1;
    localparam logic [2:0] FN_MUL = 3'd2;
    localparam logic [2:0] FN_DIV = 3'd3;
    localparam logic [2:0] FN_MAG = 3'd4;
    localparam logic [2:0] FN_ARG = 3'd5;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] re;
        logic [31:0] im;
        logic        ovf;
        logic        neg_re;
        logic        neg_im;
        logic        big_re;
        logic        big_im;
        logic        den_zero;
    } side_t;

    typedef struct packed {
        logic [63:0]             den;
        logic [63:0]             rem_re;
        logic [63:0]             rem_im;
        logic [31:0]             dvd_re;
        logic [31:0]             dvd_im;
        logic [31:0]             q_re;
        logic [31:0]             q_im;
        logic [63:0]             sq_n;
        logic [63:0]             sq_res;
        logic signed [CX_W-1:0]  cx;
        logic signed [CX_W-1:0]  cy;
        logic signed [ANG_W-1:0] cz;
        logic                    c_hold;
    } lane_t;

    function automatic logic [ANG_W-1:0] atan_q30(input int step);
        logic [ANG_W-1:0] v;
        case (step)
            0:  v = 34'd843314857;
            1:  v = 34'd497837829;
            2:  v = 34'd263043837;
            3:  v = 34'd133525159;
            4:  v = 34'd67021688;
            5:  v = 34'd33543516;
            6:  v = 34'd16775851;
            7:  v = 34'd8388437;
            8:  v = 34'd4194283;
            9:  v = 34'd2097149;
            10: v = 34'd1048576;
            11: v = 34'd524288;
            12: v = 34'd262144;
            13: v = 34'd131072;
            14: v = 34'd65536;
            15: v = 34'd32768;
            16: v = 34'd16384;
            17: v = 34'd8192;
            18: v = 34'd4096;
            19: v = 34'd2048;
            20: v = 34'd1024;
            21: v = 34'd512;
            22: v = 34'd256;
            23: v = 34'd128;
            24: v = 34'd64;
            25: v = 34'd32;
            26: v = 34'd16;
            27: v = 34'd8;
            28: v = 34'd4;
            29: v = 34'd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/cau_iter_stage.sv]
// One registered step of the iteration pipe: a restoring divide step on both
// quotient lanes, one square-root digit and, for the first CORDIC_STEPS steps, one CORDIC vectoring step. Uses cau_pkg.
module cau_iter_stage #(
    parameter int STEP = 0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  cau_pkg::side_t in_side,
    input  cau_pkg::lane_t in_lane,
    output logic           out_valid,
    output cau_pkg::side_t out_side,
    output cau_pkg::lane_t out_lane
);
    import cau_pkg::*;

    localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * STEP);
    localparam logic signed [ANG_W-1:0] ATAN_STEP = $signed(atan_q30(STEP));

    logic        valid_reg;
    side_t       side_reg;
    lane_t       lane_reg;
    lane_t       lane_next;
    logic [64:0] t_re;
    logic [64:0] t_im;
    logic [64:0] sq_sum;
    logic signed [CX_W-1:0] dx;
    logic signed [CX_W-1:0] dy;

    always_comb begin
        lane_next = in_lane;

        t_re = {in_lane.rem_re, in_lane.dvd_re[31]};
        lane_next.dvd_re = {in_lane.dvd_re[30:0], 1'b0};
        if (t_re >= {1'b0, in_lane.den}) begin
            lane_next.rem_re = 64'(t_re - {1'b0, in_lane.den});
            lane_next.q_re   = {in_lane.q_re[30:0], 1'b1};
        end else begin
            lane_next.rem_re = t_re[63:0];
            lane_next.q_re   = {in_lane.q_re[30:0], 1'b0};
        end

        t_im = {in_lane.rem_im, in_lane.dvd_im[31]};
        lane_next.dvd_im = {in_lane.dvd_im[30:0], 1'b0};
        if (t_im >= {1'b0, in_lane.den}) begin
            lane_next.rem_im = 64'(t_im - {1'b0, in_lane.den});
            lane_next.q_im   = {in_lane.q_im[30:0], 1'b1};
        end else begin
            lane_next.rem_im = t_im[63:0];
            lane_next.q_im   = {in_lane.q_im[30:0], 1'b0};
        end

        sq_sum = {1'b0, in_lane.sq_res} + {1'b0, SQ_BIT};
        if ({1'b0, in_lane.sq_n} >= sq_sum) begin
            lane_next.sq_n   = in_lane.sq_n - sq_sum[63:0];
            lane_next.sq_res = (in_lane.sq_res >> 1) + SQ_BIT;
        end else begin
            lane_next.sq_res = in_lane.sq_res >> 1;
        end

        dx = in_lane.cy >>> STEP;
        dy = in_lane.cx >>> STEP;
        if (STEP < CORDIC_STEPS && !in_lane.c_hold) begin
            if (!in_lane.cy[CX_W-1]) begin
                lane_next.cx = in_lane.cx + dx;
                lane_next.cy = in_lane.cy - dy;
                lane_next.cz = in_lane.cz + ATAN_STEP;
            end else begin
                lane_next.cx = in_lane.cx - dx;
                lane_next.cy = in_lane.cy + dy;
                lane_next.cz = in_lane.cz - ATAN_STEP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= in_side;
            lane_reg <= lane_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_lane  = lane_reg;

endmodule

[rtl/complex_arithmetic_unit.sv]
// Complex arithmetic unit top level: operand products, sums, setup stages, the
// iteration pipe and the output register. Uses cau_pkg and cau_iter_stage.
//
// Fully pipelined: one beat enters per cycle unless the result side stalls, and
// each passes three setup stages, 32 iteration stages and one output stage. The
// 32-stage iteration pipe that carries the quotient bits, the square-root digits
// and the CORDIC steps sets the latency. A stall on the result side freezes the
// whole pipe; s_tready is low exactly while a result waits and m_tready is low.
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // a_real, a_imag, b_real, b_imag (32 bits each)
    input  logic [2:0]   s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // res_real, res_imag (32 bits each)
    output logic [1:0]   m_tuser    // div_error, overflow
);
    import cau_pkg::*;

    localparam int DSH = 32 - FRAC_BITS;
    localparam int ASH = ANG_BITS - FRAC_BITS;
    localparam logic signed [ANG_W-1:0] ANG_RND = ANG_W'(1) << (ASH - 1);

    function automatic logic [32:0] sat65(input logic signed [64:0] v);
        logic [32:0] r;
        if (v[64:31] == '0 || v[64:31] == '1) begin
            r = {1'b0, v[31:0]};
        end else if (v[64]) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b1, 32'h7FFF_FFFF};
        end
        return r;
    endfunction

    function automatic logic [32:0] pack_q(input logic neg, input logic big,
                                           input logic [31:0] q);
        logic [32:0] r;
        if (!neg) begin
            if (big || q[31]) begin
                r = {1'b1, 32'h7FFF_FFFF};
            end else begin
                r = {1'b0, q};
            end
        end else begin
            if (big || (q[31] && q[30:0] != '0)) begin
                r = {1'b1, 32'h8000_0000};
            end else begin
                r = {1'b0, 32'(-q)};
            end
        end
        return r;
    endfunction

    logic advance;
    logic signed [31:0] ar, ai, br, bi, mr, mi;

    // stage 1
    logic                  p1_valid_reg;
    logic [2:0]            p1_func_reg;
    logic signed [63:0]    p1_rr_reg, p1_ii_reg, p1_ri_reg, p1_ir_reg;
    logic signed [63:0]    p1_bbr_reg, p1_bbi_reg;
    logic signed [32:0]    p1_sre_reg, p1_sim_reg;
    logic signed [32:0]    p1_sre_next, p1_sim_next;
    lane_t                 p1_lane_reg, p1_lane_next;

    // stage 2
    logic                  p2_valid_reg;
    side_t                 p2_side_reg, p2_side_next;
    logic signed [64:0]    p2_sre_reg, p2_sim_reg, p2_sre_next, p2_sim_next;
    logic [63:0]           p2_mre_reg, p2_mim_reg, p2_mre_next, p2_mim_next;
    lane_t                 p2_lane_reg, p2_lane_next;
    logic signed [64:0]    mul_re, mul_im, div_re, div_im, nd_re, nd_im;
    logic [32:0]           sat_re, sat_im;

    // stage 3
    logic                  p3_valid_reg;
    side_t                 p3_side_reg, p3_side_next;
    lane_t                 p3_lane_reg, p3_lane_next;
    logic signed [64:0]    sh_re, sh_im;
    logic [32:0]           msat_re, msat_im;

    // iteration chain
    logic                  ch_valid [ITER_STAGES+1];
    side_t                 ch_side  [ITER_STAGES+1];
    lane_t                 ch_lane  [ITER_STAGES+1];

    // output
    logic                  out_valid_reg;
    logic [63:0]           out_data_reg, out_data_next;
    logic [1:0]            out_user_reg, out_user_next;
    side_t                 fs;
    lane_t                 fl;
    logic [32:0]           fq_re, fq_im;
    logic signed [ANG_W-1:0] zsum, zr;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;

    assign ar = s_tdata[31:0];
    assign ai = s_tdata[63:32];
    assign br = s_tdata[95:64];
    assign bi = s_tdata[127:96];
    assign mr = (s_tuser == FN_MAG) ? ar : br;
    assign mi = (s_tuser == FN_MAG) ? ai : bi;

    always_comb begin
        if (s_tuser == FN_SUB) begin
            p1_sre_next = ar - br;
            p1_sim_next = ai - bi;
        end else begin
            p1_sre_next = ar + br;
            p1_sim_next = ai + bi;
        end

        p1_lane_next        = '0;
        p1_lane_next.cx     = CX_W'(ar);
        p1_lane_next.cy     = CX_W'(ai);
        if (ar == 0 && ai == 0) begin
            p1_lane_next.c_hold = 1'b1;
        end else if (ar == 0) begin
            p1_lane_next.c_hold = 1'b1;
            p1_lane_next.cz     = ai[31] ? -HALF_PI_Q30 : HALF_PI_Q30;
        end else if (ai == 0) begin
            p1_lane_next.c_hold = 1'b1;
            p1_lane_next.cz     = ar[31] ? PI_Q30 : '0;
        end else if (ar[31]) begin
            if (!ai[31]) begin
                p1_lane_next.cx = CX_W'(ai);
                p1_lane_next.cy = -CX_W'(ar);
                p1_lane_next.cz = HALF_PI_Q30;
            end else begin
                p1_lane_next.cx = -CX_W'(ai);
                p1_lane_next.cy = CX_W'(ar);
                p1_lane_next.cz = -HALF_PI_Q30;
            end
        end
    end

    always_comb begin
        mul_re = p1_rr_reg - p1_ii_reg;
        mul_im = p1_ri_reg + p1_ir_reg;
        div_re = p1_rr_reg + p1_ii_reg;
        div_im = p1_ir_reg - p1_ri_reg;
        nd_re  = -p1_rr_reg - p1_ii_reg;
        nd_im  = p1_ri_reg - p1_ir_reg;
        sat_re = sat65(65'(p1_sre_reg));
        sat_im = sat65(65'(p1_sim_reg));

        p2_sre_next = mul_re;
        p2_sim_next = mul_im;
        p2_mre_next = div_re[64] ? nd_re[63:0] : div_re[63:0];
        p2_mim_next = div_im[64] ? nd_im[63:0] : div_im[63:0];

        p2_side_next        = '0;
        p2_side_next.func   = p1_func_reg;
        p2_side_next.neg_re = div_re[64];
        p2_side_next.neg_im = div_im[64];
        if (p1_func_reg == FN_ADD || p1_func_reg == FN_SUB) begin
            p2_side_next.re  = sat_re[31:0];
            p2_side_next.im  = sat_im[31:0];
            p2_side_next.ovf = sat_re[32] | sat_im[32];
        end

        p2_lane_next     = p1_lane_reg;
        p2_lane_next.den = $unsigned(p1_bbr_reg) + $unsigned(p1_bbi_reg);
    end

    always_comb begin
        sh_re   = p2_sre_reg >>> FRAC_BITS;
        sh_im   = p2_sim_reg >>> FRAC_BITS;
        msat_re = sat65(sh_re);
        msat_im = sat65(sh_im);

        p3_side_next          = p2_side_reg;
        p3_side_next.big_re   = {32'd0, p2_mre_reg} >= ({32'd0, p2_lane_reg.den} << DSH);
        p3_side_next.big_im   = {32'd0, p2_mim_reg} >= ({32'd0, p2_lane_reg.den} << DSH);
        p3_side_next.den_zero = p2_lane_reg.den == '0;
        if (p2_side_reg.func == FN_MUL) begin
            p3_side_next.re  = msat_re[31:0];
            p3_side_next.im  = msat_im[31:0];
            p3_side_next.ovf = msat_re[32] | msat_im[32];
        end

        p3_lane_next        = p2_lane_reg;
        p3_lane_next.rem_re = p2_mre_reg >> DSH;
        p3_lane_next.rem_im = p2_mim_reg >> DSH;
        p3_lane_next.dvd_re = 32'(p2_mre_reg << FRAC_BITS);
        p3_lane_next.dvd_im = 32'(p2_mim_reg << FRAC_BITS);
        p3_lane_next.q_re   = '0;
        p3_lane_next.q_im   = '0;
        p3_lane_next.sq_n   = p2_lane_reg.den;
        p3_lane_next.sq_res = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else if (advance) begin
            p1_valid_reg <= s_tvalid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p1_func_reg <= s_tuser;
            p1_rr_reg   <= ar * br;
            p1_ii_reg   <= ai * bi;
            p1_ri_reg   <= ar * bi;
            p1_ir_reg   <= ai * br;
            p1_bbr_reg  <= mr * mr;
            p1_bbi_reg  <= mi * mi;
            p1_sre_reg  <= p1_sre_next;
            p1_sim_reg  <= p1_sim_next;
            p1_lane_reg <= p1_lane_next;
            p2_side_reg <= p2_side_next;
            p2_sre_reg  <= p2_sre_next;
            p2_sim_reg  <= p2_sim_next;
            p2_mre_reg  <= p2_mre_next;
            p2_mim_reg  <= p2_mim_next;
            p2_lane_reg <= p2_lane_next;
            p3_side_reg <= p3_side_next;
            p3_lane_reg <= p3_lane_next;
        end
    end

    assign ch_valid[0] = p3_valid_reg;
    assign ch_side[0]  = p3_side_reg;
    assign ch_lane[0]  = p3_lane_reg;

    for (genvar k = 0; k < ITER_STAGES; k++) begin : g_iter
        cau_iter_stage #(
            .STEP (k)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (advance),
            .in_valid  (ch_valid[k]),
            .in_side   (ch_side[k]),
            .in_lane   (ch_lane[k]),
            .out_valid (ch_valid[k+1]),
            .out_side  (ch_side[k+1]),
            .out_lane  (ch_lane[k+1])
        );
    end

    assign fs = ch_side[ITER_STAGES];
    assign fl = ch_lane[ITER_STAGES];

    always_comb begin
        fq_re = pack_q(fs.neg_re, fs.big_re, fl.q_re);
        fq_im = pack_q(fs.neg_im, fs.big_im, fl.q_im);
        zsum  = fl.cz + ANG_RND;
        zr    = zsum >>> ASH;
        out_data_next = '0;
        out_user_next = '0;
        case (fs.func)
            FN_ADD, FN_SUB, FN_MUL: begin
                out_data_next = {fs.im, fs.re};
                out_user_next = {fs.ovf, 1'b0};
            end
            FN_DIV: begin
                if (fs.den_zero) begin
                    out_user_next = 2'b01;
                end else begin
                    out_data_next = {fq_im[31:0], fq_re[31:0]};
                    out_user_next = {fq_re[32] | fq_im[32], 1'b0};
                end
            end
            FN_MAG: begin
                if (fl.sq_res[63:31] != '0) begin
                    out_data_next = {32'd0, 32'h7FFF_FFFF};
                    out_user_next = 2'b10;
                end else begin
                    out_data_next = {32'd0, fl.sq_res[31:0]};
                end
            end
            FN_ARG: begin
                out_data_next = {32'd0, zr[31:0]};
            end
            default: begin
                out_data_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= ch_valid[ITER_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
